// ----- sv/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg - stereo chorus delay shared definitions
// Register codes, reset values, lane control bundle and the quarter-wave sine
// series used to build the LFO table at elaboration.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BUF_LEN_W  = 17;
  localparam int GAIN_W     = 16;
  localparam int DLY_CFG_W  = 16;
  localparam int PHASE_W    = 32;
  localparam int LFO_W      = 17;
  localparam int MIN_LEN    = 4;
  localparam int TAP_OFFSET = 3;
  localparam int GAIN_SHIFT = 15;
  localparam int LFO_FRAC_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_ENABLE = 3'd5;

  localparam logic [BUF_LEN_W-1:0] RST_BUFFER_LENGTH = 17'd44100;
  localparam logic [DLY_CFG_W-1:0] RST_BASE_DELAY    = 16'd882;
  localparam logic [DLY_CFG_W-1:0] RST_SWEEP_WIDTH   = 16'd220;
  localparam logic [GAIN_W-1:0]    RST_DEPTH_GAIN    = 16'd32768;
  localparam logic [PHASE_W-1:0]   RST_PHASE_STEP    = 32'd292175;
  localparam logic                 RST_STEREO_ENABLE = 1'b1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef struct packed {
    logic we;
    logic ld_a;
    logic calc_interp;
    logic calc_wet;
  } scd_lane_ctl_t;

  function automatic logic [30:0] scd_quarter_sine(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q30)) begin
      acc = longint'(ONE_Q30);
    end
    return 31'(acc);
  endfunction

endpackage

// ----- sv/scd_lfo.sv -----
// ----------------------------------------------------------------------------
// scd_lfo - chorus LFO
// Phase accumulator and registered sine table giving 1 + 0.5 sin in Q16 per item.
// ----------------------------------------------------------------------------
module scd_lfo
  import scd_pkg::*;
#(
  parameter int TBL_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [PHASE_W-1:0] phase_step,
  output logic [LFO_W-1:0]   u
);

  localparam int TAW = $clog2(TBL_DEPTH);
  localparam int KPW = PHASE_W + $clog2(TBL_DEPTH + 1);

  typedef logic [LFO_W-1:0] rom_t [TBL_DEPTH];

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] f;
    logic [63:0] r;
    logic [30:0] s;
    logic [63:0] num;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      f = (64'(k) << PHASE_W) / TBL_DEPTH;
      r = f & (ONE_Q30 - 64'd1);
      if (f[30]) begin
        r = ONE_Q30 - r;
      end
      s = scd_quarter_sine(r);
      if (f[31]) begin
        num = (ONE_Q30 << 1) - 64'(s);
      end else begin
        num = (ONE_Q30 << 1) + 64'(s);
      end
      t[k] = LFO_W'(num >> 15);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [PHASE_W-1:0] phase_r;
  logic [LFO_W-1:0]   u_r;
  logic [KPW-1:0]     kp;
  logic [TAW-1:0]     k;

  assign kp = KPW'(phase_r) * KPW'(TBL_DEPTH);
  assign k  = kp[PHASE_W +: TAW];
  assign u  = u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (advance) begin
      phase_r <= phase_r + phase_step;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= ROM[k];
  end

endmodule

// ----- sv/scd_lane.sv -----
// ----------------------------------------------------------------------------
// scd_lane - one chorus channel
// Circular delay store, two-tap linear interpolation, wet gain and saturation.
// ----------------------------------------------------------------------------
module scd_lane
  import scd_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int FB    = 8
) (
  input  logic                       clk,
  input  scd_lane_ctl_t              ctl,
  input  logic [AW-1:0]              addr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic [FB-1:0]              frac,
  input  logic [GAIN_W-1:0]          gain,
  input  logic signed [SAMPLE_W-1:0] dry,
  output logic signed [SAMPLE_W-1:0] y,
  output logic                       clip
);

  localparam int SW  = SAMPLE_W;
  localparam int IPW = SW + FB + 2;
  localparam int WPW = SW + GAIN_W + 1;
  localparam int WW  = SW + 2;
  localparam int YW  = SW + 3;

  logic signed [SW-1:0] mem [DEPTH];
  logic signed [SW-1:0] q_r;
  logic signed [SW-1:0] a_r;
  logic signed [SW-1:0] interp_r;
  logic signed [WW-1:0] wet_r;

  logic signed [SW:0]    diff;
  logic signed [FB:0]    frac_s;
  logic signed [IPW-1:0] ip_prod;
  logic signed [IPW-1:0] ip_shift;
  logic signed [SW-1:0]  interp_nxt;
  logic signed [WPW-1:0] w_prod;
  logic signed [WPW-1:0] w_shift;
  logic signed [YW-1:0]  ysum;
  logic                  ovf;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end else begin
      q_r <= mem[addr];
    end
  end

  assign diff       = (SW+1)'(q_r) - (SW+1)'(a_r);
  assign frac_s     = $signed({1'b0, frac});
  assign ip_prod    = IPW'(diff) * IPW'(frac_s);
  assign ip_shift   = ip_prod >>> FB;
  assign interp_nxt = SW'((SW+1)'(a_r) + (SW+1)'(ip_shift));
  assign w_prod     = WPW'(interp_r) * WPW'($signed({1'b0, gain}));
  assign w_shift    = w_prod >>> GAIN_SHIFT;

  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      a_r <= q_r;
    end
    if (ctl.calc_interp) begin
      interp_r <= interp_nxt;
    end
    if (ctl.calc_wet) begin
      wet_r <= WW'(w_shift);
    end
  end

  assign ysum = YW'(dry) + YW'(wet_r);
  assign ovf  = (ysum[YW-1:SW-1] != {4{ysum[YW-1]}});
  assign clip = ovf;

  always_comb begin
    if (!ovf) begin
      y = ysum[SW-1:0];
    end else if (ysum[YW-1]) begin
      y = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

// ----- sv/scd_merge.sv -----
// ----------------------------------------------------------------------------
// scd_merge - lane merge and result register
// Combine both lanes and their clip flags, hold the item for the receiver.
// ----------------------------------------------------------------------------
module scd_merge
  import scd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       stereo,
  input  logic signed [SAMPLE_W-1:0] yl,
  input  logic signed [SAMPLE_W-1:0] yr,
  input  logic                       clip_l,
  input  logic                       clip_r,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  output logic                       out_clipped,
  output logic                       free
);

  logic                       valid_r;
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic                       clip_r_q;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r   <= yl;
      right_r  <= stereo ? yr : '0;
      clip_r_q <= clip_l || (stereo && clip_r);
    end
  end

  assign out_valid     = valid_r;
  assign out_left_out  = left_r;
  assign out_right_out = right_r;
  assign out_clipped   = clip_r_q;

endmodule

// ----- sv/stereo_chorus_delay.sv -----
// ----------------------------------------------------------------------------
// stereo_chorus_delay - stereo chorus with sine LFO and linear interpolation
//
// Input channel in_valid/in_ready carries one stereo sample pair per item;
// output channel out_valid/out_ready returns one saturated pair plus a clip
// flag per item. Registers must be written through cfg_we/cfg_index/cfg_wdata
// only while no item is in flight; the block itself does not enforce this.
// An item steps through acceptance, then LFO multiply, delay clamp,
// read position, two reads of each lane's single-port delay store,
// interpolation, wet gain and a final state that writes the store and loads
// the result register. A new item is taken only after the previous one leaves
// its final state. Both lanes run side by side.
// After reset both delay stores are cleared one entry per cycle, all MAX_DELAY
// entries, with in_ready low. When the receiver stalls, one result waits in
// the output register while the next item is processed; that item then
// holds in its final cycle until the register frees.
// ----------------------------------------------------------------------------
module stereo_chorus_delay
  import scd_pkg::*;
#(
  parameter int MAX_DELAY        = 65536,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_left_in,
  input  logic signed [SAMPLE_W-1:0] in_right_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  output logic                       out_clipped,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int FB     = FRACTION_BITS;
  localparam int AW     = $clog2(MAX_DELAY);
  localparam int LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int LW     = (LEN_W > BUF_LEN_W) ? LEN_W : BUF_LEN_W;
  localparam int QW     = LEN_W + FB;
  localparam int PW     = DLY_CFG_W + LFO_W;
  localparam int PSH    = LFO_FRAC_W - FB;
  localparam int DLY_W  = PW + FB + 2;
  localparam int CW     = (DLY_W > QW) ? DLY_W : QW;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_DLY  = 4'd3;
  localparam logic [3:0] ST_POS  = 4'd4;
  localparam logic [3:0] ST_RDA  = 4'd5;
  localparam logic [3:0] ST_RDB  = 4'd6;
  localparam logic [3:0] ST_INT  = 4'd7;
  localparam logic [3:0] ST_WET  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  logic [BUF_LEN_W-1:0] cfg_buffer_length_r;
  logic [DLY_CFG_W-1:0] cfg_base_delay_r;
  logic [DLY_CFG_W-1:0] cfg_sweep_width_r;
  logic [GAIN_W-1:0]    cfg_depth_gain_r;
  logic [PHASE_W-1:0]   cfg_phase_step_r;
  logic                 cfg_stereo_enable_r;

  logic [3:0]    state_r;
  logic [3:0]    state_nxt;
  logic [AW-1:0] clr_r;
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;

  logic [LEN_W-1:0]           len_r;
  logic signed [SAMPLE_W-1:0] dry_l_r;
  logic signed [SAMPLE_W-1:0] dry_r_r;
  logic [PW-1:0]              prod_r;
  logic [QW-1:0]              dly_r;
  logic [AW-1:0]              prev_r;
  logic [AW-1:0]              next_r;
  logic [FB-1:0]              frac_r;

  logic [LW-1:0]    blen;
  logic [LEN_W-1:0] len_c;
  logic             accept;
  logic             finish;
  logic             out_free;
  logic [LFO_W-1:0] u;
  logic [CW-1:0]    dsum;
  logic [CW-1:0]    lim;
  logic [QW:0]      pdiff;
  logic [QW-1:0]    lenq;
  logic [QW-1:0]    pos_c;
  logic [LEN_W-1:0] nx;
  logic [LEN_W-1:0] wpx;

  logic [AW-1:0]              mem_addr;
  logic signed [SAMPLE_W-1:0] wd_l;
  logic signed [SAMPLE_W-1:0] wd_r;
  scd_lane_ctl_t              ctl_l;
  scd_lane_ctl_t              ctl_r;
  logic signed [SAMPLE_W-1:0] yl;
  logic signed [SAMPLE_W-1:0] yr;
  logic                       clip_l;
  logic                       clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_buffer_length_r <= RST_BUFFER_LENGTH;
      cfg_base_delay_r    <= RST_BASE_DELAY;
      cfg_sweep_width_r   <= RST_SWEEP_WIDTH;
      cfg_depth_gain_r    <= RST_DEPTH_GAIN;
      cfg_phase_step_r    <= RST_PHASE_STEP;
      cfg_stereo_enable_r <= RST_STEREO_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUFFER_LENGTH: cfg_buffer_length_r <= cfg_wdata[BUF_LEN_W-1:0];
        REG_BASE_DELAY:    cfg_base_delay_r    <= cfg_wdata[DLY_CFG_W-1:0];
        REG_SWEEP_WIDTH:   cfg_sweep_width_r   <= cfg_wdata[DLY_CFG_W-1:0];
        REG_DEPTH_GAIN:    cfg_depth_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_PHASE_STEP:    cfg_phase_step_r    <= cfg_wdata[PHASE_W-1:0];
        REG_STEREO_ENABLE: cfg_stereo_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == ST_FIN) && out_free;

  always_comb begin
    blen = LW'(cfg_buffer_length_r);
    if (blen < LW'(MIN_LEN)) begin
      len_c = LEN_W'(MIN_LEN);
    end else if (blen > LW'(MAX_DELAY)) begin
      len_c = LEN_W'(MAX_DELAY);
    end else begin
      len_c = LEN_W'(blen);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_r == AW'(MAX_DELAY - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DLY;
      ST_DLY:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_INT;
      ST_INT:  state_nxt = ST_WET;
      ST_WET:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  assign wpx = LEN_W'(wp_r) + LEN_W'(1);

  always_comb begin
    wp_nxt = wp_r;
    if (accept && (LEN_W'(wp_r) >= len_c)) begin
      wp_nxt = '0;
    end else if (finish) begin
      wp_nxt = (wpx >= len_r) ? '0 : AW'(wpx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      wp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  assign lenq  = QW'(len_r) << FB;
  assign lim   = CW'(lenq) - CW'(1);
  assign dsum  = (CW'(cfg_base_delay_r) << FB) + CW'(prod_r >> PSH)
               + (CW'(TAP_OFFSET) << FB);
  assign pdiff = {1'b0, QW'(wp_r) << FB} - {1'b0, dly_r};
  assign pos_c = pdiff[QW] ? (pdiff[QW-1:0] + lenq) : pdiff[QW-1:0];
  assign nx    = LEN_W'(prev_r) + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      len_r   <= len_c;
      dry_l_r <= in_left_in;
      dry_r_r <= in_right_in;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PW'(cfg_sweep_width_r) * PW'(u);
    end
    if (state_r == ST_DLY) begin
      dly_r <= (dsum > lim) ? QW'(lim) : QW'(dsum);
    end
    if (state_r == ST_POS) begin
      prev_r <= pos_c[FB +: AW];
      frac_r <= pos_c[FB-1:0];
    end
    if (state_r == ST_RDA) begin
      next_r <= (nx >= len_r) ? '0 : AW'(nx);
    end
  end

  always_comb begin
    unique case (state_r)
      ST_CLR:  mem_addr = clr_r;
      ST_RDA:  mem_addr = prev_r;
      ST_RDB:  mem_addr = next_r;
      default: mem_addr = wp_r;
    endcase
  end

  assign wd_l = (state_r == ST_CLR) ? '0 : dry_l_r;
  assign wd_r = (state_r == ST_CLR) ? '0 : dry_r_r;

  assign ctl_l.we          = (state_r == ST_CLR) || finish;
  assign ctl_l.ld_a        = (state_r == ST_RDB);
  assign ctl_l.calc_interp = (state_r == ST_INT);
  assign ctl_l.calc_wet    = (state_r == ST_WET);

  assign ctl_r.we          = (state_r == ST_CLR) || (finish && cfg_stereo_enable_r);
  assign ctl_r.ld_a        = ctl_l.ld_a;
  assign ctl_r.calc_interp = ctl_l.calc_interp;
  assign ctl_r.calc_wet    = ctl_l.calc_wet;

  scd_lfo #(
    .TBL_DEPTH(SINE_TABLE_DEPTH)
  ) u_lfo (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (finish),
    .phase_step(cfg_phase_step_r),
    .u         (u)
  );

  scd_lane #(
    .DEPTH(MAX_DELAY),
    .AW   (AW),
    .FB   (FB)
  ) u_lane_l (
    .clk  (clk),
    .ctl  (ctl_l),
    .addr (mem_addr),
    .wdata(wd_l),
    .frac (frac_r),
    .gain (cfg_depth_gain_r),
    .dry  (dry_l_r),
    .y    (yl),
    .clip (clip_l)
  );

  scd_lane #(
    .DEPTH(MAX_DELAY),
    .AW   (AW),
    .FB   (FB)
  ) u_lane_r (
    .clk  (clk),
    .ctl  (ctl_r),
    .addr (mem_addr),
    .wdata(wd_r),
    .frac (frac_r),
    .gain (cfg_depth_gain_r),
    .dry  (dry_r_r),
    .y    (yr),
    .clip (clip_r)
  );

  scd_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (finish),
    .stereo       (cfg_stereo_enable_r),
    .yl           (yl),
    .yr           (yr),
    .clip_l       (clip_l),
    .clip_r       (clip_r),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .out_clipped  (out_clipped),
    .free         (out_free)
  );

endmodule

// ----- sv/scd_check.sv -----
// ----------------------------------------------------------------------------
// scd_check - port-level checks for the stereo chorus delay
// Watches handshakes, reset behavior and mono output over time.
// ----------------------------------------------------------------------------
module scd_check
  import scd_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_left_out,
  input logic signed [SAMPLE_W-1:0] out_right_out,
  input logic                       out_clipped,
  input logic                       cfg_we,
  input logic [CFG_IDX_W-1:0]       cfg_index,
  input logic [CFG_DATA_W-1:0]      cfg_wdata
);

  logic       stereo_r;
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= RST_STEREO_ENABLE;
      pend_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_STEREO_ENABLE)) begin
        stereo_r <= cfg_wdata[0];
      end
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ports not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out)
      && $stable(out_right_out) && $stable(out_clipped))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted item");

  a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !stereo_r |-> out_right_out == '0)
    else $error("right output nonzero in mono mode");

endmodule

bind stereo_chorus_delay scd_check u_scd_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_left_out (out_left_out),
  .out_right_out(out_right_out),
  .out_clipped  (out_clipped),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .cfg_wdata    (cfg_wdata)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - stereo chorus delay check
// Streams stereo sample pairs through the chorus under a series of register
// settings. A scoreboard class keeps its own copy of the delay lines, the LFO
// phase and the write position, predicts every output pair and compares it
// field by field with what the block returns. Sender bursts, receiver stalls
// and two long receiver hold-offs exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench
  import scd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH  = 65536;
  localparam int SINE_DEPTH  = 1024;
  localparam int FRAC_W      = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_CORNER    = 20;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       clip;
  } chorus_pair_t;

  class chorus_scoreboard;
    logic signed [SAMPLE_W-1:0] left_line [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] right_line [LINE_DEPTH];
    int unsigned                wr_pos;
    bit [PHASE_W-1:0]           lfo_acc;
    bit [BUF_LEN_W-1:0]         buf_len;
    bit [DLY_CFG_W-1:0]         base_dly;
    bit [DLY_CFG_W-1:0]         sweep;
    bit [GAIN_W-1:0]            wet_gain;
    bit [PHASE_W-1:0]           lfo_step;
    bit                         stereo_on;
    bit                         clip_flag;
    chorus_pair_t               expected_q[$];
    int                         errors;

    function new();
      foreach (left_line[i]) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      wr_pos    = 0;
      lfo_acc   = '0;
      buf_len   = RST_BUFFER_LENGTH;
      base_dly  = RST_BASE_DELAY;
      sweep     = RST_SWEEP_WIDTH;
      wet_gain  = RST_DEPTH_GAIN;
      lfo_step  = RST_PHASE_STEP;
      stereo_on = RST_STEREO_ENABLE;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        REG_BUFFER_LENGTH: buf_len   = val[BUF_LEN_W-1:0];
        REG_BASE_DELAY:    base_dly  = val[DLY_CFG_W-1:0];
        REG_SWEEP_WIDTH:   sweep     = val[DLY_CFG_W-1:0];
        REG_DEPTH_GAIN:    wet_gain  = val[GAIN_W-1:0];
        REG_PHASE_STEP:    lfo_step  = val[PHASE_W-1:0];
        REG_STEREO_ENABLE: stereo_on = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned quarter_wave(longint unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div;
      longint          acc;
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        div  = 64'(2 * n * (2 * n + 1));
        term = ((term * x2) >> 30) / div;
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      return longint'(acc);
    endfunction

    function longint unsigned lfo_q16(bit [PHASE_W-1:0] ph);
      longint unsigned k;
      longint unsigned f;
      longint unsigned r;
      longint unsigned s;
      longint unsigned quad;
      k    = ({32'd0, ph} * 64'(SINE_DEPTH)) >> 32;
      f    = (k << 32) / 64'(SINE_DEPTH);
      quad = (f >> 30) & 64'd3;
      r    = f & (ONE_Q30 - 64'd1);
      if (quad[0]) r = ONE_Q30 - r;
      s = quarter_wave(r);
      if (quad[1]) return (64'd2 * ONE_Q30 - s) >> 15;
      return (64'd2 * ONE_Q30 + s) >> 15;
    endfunction

    function logic signed [SAMPLE_W-1:0] mix_lane(bit right_side,
                                                  logic signed [SAMPLE_W-1:0] dry,
                                                  int unsigned prev, int unsigned next,
                                                  int unsigned frac);
      longint a;
      longint b;
      longint fr;
      longint g;
      longint interp;
      longint wet;
      longint y;
      if (right_side) begin
        a = longint'(right_line[prev]);
        b = longint'(right_line[next]);
        right_line[wr_pos] = dry;
      end else begin
        a = longint'(left_line[prev]);
        b = longint'(left_line[next]);
        left_line[wr_pos] = dry;
      end
      fr     = longint'(frac);
      g      = longint'(wet_gain);
      interp = (fr * b + ((longint'(1) << FRAC_W) - fr) * a) >>> FRAC_W;
      wet    = (interp * g) >>> GAIN_SHIFT;
      y      = longint'(dry) + wet;
      if (y > 32767) begin
        y = 32767;
        clip_flag = 1'b1;
      end
      if (y < -32768) begin
        y = -32768;
        clip_flag = 1'b1;
      end
      return y[SAMPLE_W-1:0];
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      int unsigned     len;
      int unsigned     prev;
      int unsigned     next;
      int unsigned     frac;
      longint unsigned u;
      longint unsigned dly;
      longint unsigned lenq;
      longint unsigned pos;
      chorus_pair_t    res;
      len = 32'(buf_len);
      if (len < MIN_LEN) len = MIN_LEN;
      if (len > LINE_DEPTH) len = LINE_DEPTH;
      if (wr_pos >= len) wr_pos = 0;
      u    = lfo_q16(lfo_acc);
      dly  = (64'(base_dly) << FRAC_W) + ((64'(sweep) * u) >> (LFO_FRAC_W - FRAC_W))
           + (64'(TAP_OFFSET) << FRAC_W);
      lenq = 64'(len) << FRAC_W;
      if (dly > lenq - 1) dly = lenq - 1;
      pos = (64'(wr_pos) << FRAC_W) + lenq - dly;
      if (pos >= lenq) pos = pos - lenq;
      prev = 32'(pos >> FRAC_W);
      frac = 32'(pos & ((64'd1 << FRAC_W) - 1));
      next = prev + 1;
      if (next >= len) next = 0;
      clip_flag = 1'b0;
      res.left  = mix_lane(1'b0, l, prev, next, frac);
      if (stereo_on) res.right = mix_lane(1'b1, r, prev, next, frac);
      else res.right = '0;
      res.clip = clip_flag;
      wr_pos++;
      if (wr_pos >= len) wr_pos = 0;
      lfo_acc = lfo_acc + lfo_step;
      expected_q.push_back(res);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                               logic c);
      chorus_pair_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: L=%0d R=%0d clip=%0b", l, r, c);
        return;
      end
      want = expected_q.pop_front();
      if (l !== want.left || r !== want.right || c !== want.clip) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected L=%0d R=%0d clip=%0b, got L=%0d R=%0d clip=%0b",
                   want.left, want.right, want.clip, l, r, c);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_left_in;
  logic signed [SAMPLE_W-1:0] in_right_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_left_out;
  logic signed [SAMPLE_W-1:0] out_right_out;
  logic                       out_clipped;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  chorus_scoreboard sb;
  bit               hold_req;
  int               cycle_count;
  int               corner_idx;

  logic signed [SAMPLE_W-1:0] corner_l [N_CORNER] = '{
    32767, -32768, 32767, -32768, 0, -1, 1, 21845, -21846, 32767,
    32767, -32768, 32767, -32768, -32768, 32767, 16384, -16385, 0, -1};
  logic signed [SAMPLE_W-1:0] corner_r [N_CORNER] = '{
    -32768, 32767, 32767, -32768, -1, 0, -1, -21846, 21845, 32767,
    -32768, -32768, -32768, 32767, -32768, 32767, -16385, 16384, -1, 0};

  stereo_chorus_delay i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .out_clipped   (out_clipped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : result_sink
    int     hold_left;
    int     seg_left;
    int     mode;
    bit [7:0] pat;
    hold_left = 0;
    seg_left  = 0;
    mode      = 0;
    pat       = 8'b1011_0010;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_output(out_left_out, out_right_out, out_clipped);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 120);
        pat      = 8'($urandom);
      end
      seg_left--;
      pat = {pat[6:0], pat[7]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= pat[0];
        endcase
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2, 3: begin
        v = SAMPLE_W'($urandom_range(0, 511));
        v = v - 16'sd256;
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_input(l, r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(input bit [31:0] len, input bit [31:0] base,
                              input bit [31:0] swp, input bit [31:0] gain,
                              input bit [31:0] stp, input bit [31:0] stereo);
    write_reg(REG_BUFFER_LENGTH, len);
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_SWEEP_WIDTH, swp);
    write_reg(REG_DEPTH_GAIN, gain);
    write_reg(REG_PHASE_STEP, stp);
    write_reg(REG_STEREO_ENABLE, stereo);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n_items, input bit directed, input bit gapless);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 10);
    for (int i = 0; i < n_items; i++) begin
      if (directed && corner_idx < N_CORNER) begin
        send_pair(corner_l[corner_idx], corner_r[corner_idx]);
        corner_idx++;
      end else begin
        send_pair(pick_sample(), pick_sample());
      end
      burst_left--;
      if (burst_left == 0) begin
        gap = gapless ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
    end
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    bit [31:0] len;
    bit [31:0] base;
    bit [31:0] swp;
    bit [31:0] gain;
    bit [31:0] stp;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_left_in  <= '0;
    in_right_in <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_BUFFER_LENGTH;
    cfg_wdata   <= '0;
    hold_req    = 1'b0;
    corner_idx  = 0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(30, 1'b0, 1'b0);

    // extremes with a tiny line and high wet gain, then a clamped delay
    program_regs(2, 0, 1, 65535, 32'h2000_0000, 1);
    run_phase(12, 1'b1, 1'b0);
    program_regs(3, 9, 0, 32768, 32'hffff_ffff, 1);
    run_phase(8, 1'b1, 1'b0);

    // full-length line with maximal delay; receiver holds off meanwhile
    program_regs(131071, 65535, 65535, 32768, 32'h4000_0000, 1);
    hold_req = 1'b1;
    run_phase(40, 1'b0, 1'b1);

    // shrink the line under the write position, mono
    program_regs(5, 1, 3, 0, 0, 0);
    run_phase(40, 1'b0, 1'b0);

    program_regs(16, 2, 10, 40000, $urandom, 1);
    run_phase(40, 1'b0, 1'b0);

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(65, 131071);
        2: len = 65536;
        default: len = $urandom_range(4, 64);
      endcase
      base = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
      swp  = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 40);
      case ($urandom_range(0, 5))
        0: gain = 0;
        1: gain = 32768;
        default: gain = $urandom_range(0, 65535);
      endcase
      stp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 22) : $urandom;
      program_regs(len, base, swp, gain, stp, $urandom_range(0, 1));
      if (p == 5) hold_req = 1'b1;
      run_phase(50, 1'b0, (p == 5) || ($urandom_range(0, 3) == 0));
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
